FILE: sv/afcu_pkg.sv
// Shared types and constants for the ADC frame channel unpacker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package afcu_pkg;

  // Default number of channels in one conversion frame
  localparam int unsigned NumChannelsDef = 8;

  // Field widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CodeW  = 20;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned TagW   = 3;
  localparam int unsigned PosW   = 6;
  localparam int unsigned HeldW  = 16;
  localparam int unsigned WordW  = HeldW + ByteW;
  // Wide enough for the largest channel count a 6-bit position can produce
  localparam int unsigned ChW    = 5;
  localparam int unsigned TdataW = 48;

  // Packet format register codes
  typedef enum logic [1:0] {
    FMT_PACKED20 = 2'd0,
    FMT_WIDE24   = 2'd1,
    FMT_WIDE32   = 2'd2,
    FMT_INVALID  = 2'd3
  } afcu_fmt_e;

  // One decoded result
  typedef struct packed {
    logic                    bad_format;
    logic                    frame_done;
    logic [TagW-1:0]         channel_tag;
    logic                    range_flag;
    logic signed [CodeW-1:0] signed_value;
    logic [CodeW-1:0]        raw_value;
    logic [IdxW-1:0]         channel_index;
  } afcu_result_t;

endpackage

`default_nettype wire

FILE: sv/afcu_decode.sv
// Frame position tracking and channel decode for the ADC frame unpacker.
// Depends on afcu_pkg for the format codes and the result type.
`timescale 1ns / 1ps
`default_nettype none

module afcu_decode #(
  parameter int unsigned NUM_CHANNELS = afcu_pkg::NumChannelsDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       adv_i,
  input  wire logic [afcu_pkg::ByteW-1:0] byte_i,
  input  wire logic                       start_i,
  input  wire afcu_pkg::afcu_fmt_e        fmt_i,
  output logic                            res_valid_o,
  output afcu_pkg::afcu_result_t          res_o
);
  import afcu_pkg::*;

  localparam int unsigned Len20 = (20 * NUM_CHANNELS + 7) / 8;
  localparam int unsigned Len24 = 3 * NUM_CHANNELS;
  localparam int unsigned Len32 = 4 * NUM_CHANNELS;

  logic [PosW-1:0]  pos_q, pos_d;
  logic [HeldW-1:0] held_q, held_d;
  logic             active_q, active_d;

  logic [PosW-1:0]  pos;
  logic [PosW-1:0]  pos_nxt;
  logic [WordW-1:0] word;
  logic             active;
  logic             bad_start;
  logic [11:0]      prod5;
  logic [12:0]      prod3;
  logic [3:0]       k5;
  logic [4:0]       k3;
  logic [PosW-1:0]  r5_w;
  logic [PosW-1:0]  r3_w;
  logic [ChW-1:0]   ch;
  logic [CodeW-1:0] raw;
  logic             flag;
  logic [TagW-1:0]  tag;
  logic             emit;
  logic [6:0]       len;

  // Working position and byte window; a start byte restarts the frame
  always_comb begin
    pos       = start_i ? '0 : pos_q;
    word      = {start_i ? {HeldW{1'b0}} : held_q, byte_i};
    bad_start = start_i && (fmt_i == FMT_INVALID);
    active    = start_i ? (fmt_i != FMT_INVALID) : active_q;
    pos_nxt   = pos + PosW'(1);
  end

  // Quotient and remainder of the position by five and by three, via reciprocals
  always_comb begin
    prod5 = 12'(pos) * 12'd13;
    k5    = prod5[9:6];
    r5_w  = pos - ((PosW'(k5) << 2) + PosW'(k5));
    prod3 = 13'(pos) * 13'd43;
    k3    = prod3[11:7];
    r3_w  = pos - ((PosW'(k3) << 1) + PosW'(k3));
  end

  // Channel decode for the current format
  always_comb begin
    ch   = '0;
    raw  = '0;
    flag = 1'b0;
    tag  = '0;
    emit = 1'b0;
    len  = '0;
    case (fmt_i)
      FMT_PACKED20: begin
        len = 7'(Len20);
        if (r5_w[2:0] == 3'd2) begin
          ch   = {k5, 1'b0};
          raw  = word[WordW-1:4];
          emit = 1'b1;
        end else if (r5_w[2:0] == 3'd4) begin
          ch   = {k5, 1'b1};
          raw  = word[CodeW-1:0];
          emit = 1'b1;
        end
      end
      FMT_WIDE24: begin
        len = 7'(Len24);
        if (r3_w[1:0] == 2'd2) begin
          ch   = k3;
          raw  = word[WordW-1:4];
          flag = byte_i[3];
          tag  = byte_i[TagW-1:0];
          emit = 1'b1;
        end
      end
      FMT_WIDE32: begin
        len = 7'(Len32);
        if (pos[1:0] == 2'd2) begin
          ch   = {1'b0, pos[PosW-1:2]};
          raw  = word[WordW-1:4];
          flag = byte_i[3];
          tag  = byte_i[TagW-1:0];
          emit = 1'b1;
        end
      end
      default: begin
        len = '0;
      end
    endcase
  end

  // Result assembly
  always_comb begin
    res_o       = '0;
    res_valid_o = 1'b0;
    if (bad_start) begin
      res_o.bad_format = 1'b1;
      res_valid_o      = adv_i;
    end else begin
      res_o.channel_index = ch[IdxW-1:0];
      res_o.raw_value     = raw;
      res_o.signed_value  = raw;
      res_o.range_flag    = flag;
      res_o.channel_tag   = tag;
      res_o.frame_done    = (ch == ChW'(NUM_CHANNELS - 1));
      res_valid_o         = adv_i && active && emit && (ch < ChW'(NUM_CHANNELS));
    end
  end

  // Next frame state
  always_comb begin
    pos_d    = pos_q;
    held_d   = held_q;
    active_d = active_q;
    if (adv_i) begin
      if (bad_start) begin
        pos_d    = '0;
        held_d   = '0;
        active_d = 1'b0;
      end else if (active) begin
        pos_d    = pos_nxt;
        held_d   = word[HeldW-1:0];
        active_d = !((fmt_i == FMT_INVALID) || ({1'b0, pos_nxt} >= len));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      held_q   <= '0;
      active_q <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      held_q   <= held_d;
      active_q <= active_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/afcu_out_buf.sv
// Two-entry result buffer: output register plus skid entry.
// Depends on afcu_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none

module afcu_out_buf (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_i,
  input  wire afcu_pkg::afcu_result_t push_data_i,
  output logic                        room_o,
  output logic                        valid_o,
  input  wire logic                   ready_i,
  output afcu_pkg::afcu_result_t      data_o
);
  import afcu_pkg::*;

  logic [1:0]   count_q, count_d;
  afcu_result_t head_q, head_d;
  afcu_result_t skid_q, skid_d;
  logic         pop;

  assign pop     = (count_q != 2'd0) && ready_i;
  assign room_o  = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = head_q;

  // A push only arrives while there is room, so the buffer never overflows
  always_comb begin
    count_d = count_q;
    head_d  = head_q;
    skid_d  = skid_q;
    case ({push_i, pop})
      2'b10: begin
        count_d = count_q + 2'd1;
        if (count_q == 2'd0) begin
          head_d = push_data_i;
        end else begin
          skid_d = push_data_i;
        end
      end
      2'b01: begin
        count_d = count_q - 2'd1;
        head_d  = skid_q;
      end
      2'b11: begin
        head_d = push_data_i;
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

endmodule

`default_nettype wire

FILE: sv/adc_frame_channel_unpacker.sv
// Top level of the ADC frame channel unpacker: input register, format register,
// decode stage and result buffer. Depends on afcu_pkg, afcu_decode, afcu_out_buf.
`timescale 1ns / 1ps
`default_nettype none

// Byte-serial unpacker for ADC conversion frames of NUM_CHANNELS channels
// (eight by default). One frame byte is accepted every clock cycle while the
// output buffer has room; a byte with s_axis_tuser high opens a new frame.
// Each byte is held in an input register and decoded there against the frame
// position and the two previous bytes, and any channel result is registered
// into a two-entry output buffer whose head entry is presented on the master
// side. The input keeps taking one byte per cycle as long as the output buffer
// has room; backpressure on the master side stalls the input only once both
// buffer entries are full. The packet format register (20-bit packed, 24-bit,
// 32-bit) must only be written while no requests are outstanding; a write
// inside a frame applies to the bytes that follow it.
module adc_frame_channel_unpacker #(
  parameter int unsigned NUM_CHANNELS = afcu_pkg::NumChannelsDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // Configuration: packet format
  input  wire logic                        cfg_we_i,
  input  wire logic [1:0]                  cfg_wdata_i,
  // Frame bytes in
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [afcu_pkg::ByteW-1:0]  s_axis_tdata,  // [7:0] rx_byte
  input  wire logic                        s_axis_tuser,  // [0] frame_start
  // Channel results out
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // [2:0] channel_index, [22:3] raw_value, [42:23] signed_value,
  // [43] range_flag, [46:44] channel_tag, [47] zero
  output logic [afcu_pkg::TdataW-1:0]      m_axis_tdata,
  output logic                             m_axis_tlast,  // frame_done
  output logic                             m_axis_tuser   // [0] bad_format
);
  import afcu_pkg::*;

  afcu_fmt_e        fmt_q;
  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_start_q;
  logic             adv;
  logic             room;
  logic             res_valid;
  afcu_result_t     res;
  afcu_result_t     out_res;

  // Packet format register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_PACKED20;
    end else if (cfg_we_i) begin
      fmt_q <= afcu_fmt_e'(cfg_wdata_i);
    end
  end

  // Input register; it moves on whenever the result buffer has room
  assign adv           = in_valid_q && room;
  assign s_axis_tready = !in_valid_q || room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q  <= s_axis_tdata;
      in_start_q <= s_axis_tuser;
    end
  end

  afcu_decode #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .byte_i      (in_byte_q),
    .start_i     (in_start_q),
    .fmt_i       (fmt_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  afcu_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .room_o      (room),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .data_o      (out_res)
  );

  // Pack the result onto the master side
  assign m_axis_tdata = {1'b0, out_res.channel_tag, out_res.range_flag,
                         out_res.signed_value, out_res.raw_value,
                         out_res.channel_index};
  assign m_axis_tlast = out_res.frame_done;
  assign m_axis_tuser = out_res.bad_format;

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for adc_frame_channel_unpacker: drives frame bytes and format
// writes, predicts each channel result and checks it. Depends on afcu_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
  import afcu_pkg::*;

  localparam int unsigned NCH = NumChannelsDef;
  localparam int unsigned PERIOD = 12;

  // Clock, reset and block inputs, all at known values from time zero
  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [1:0]        cfg_wdata_i   = 2'd0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [ByteW-1:0]  s_axis_tdata  = '0;
  logic              s_axis_tuser  = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [TdataW-1:0] m_axis_tdata;
  logic              m_axis_tlast;
  logic              m_axis_tuser;

  // Predictor state, mirroring the block's frame tracking
  afcu_fmt_e   fmt_q        = FMT_PACKED20;
  logic [5:0]  pos_q        = '0;
  logic [15:0] held_q       = '0;
  logic        frame_open_q = 1'b0;

  afcu_result_t expected_channels[$];
  int unsigned  mismatch_count = 0;
  int unsigned  bytes_decoded  = 0;
  int unsigned  idle_pct       = 0;
  int unsigned  stall_pct      = 0;

  adc_frame_channel_unpacker uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #(PERIOD / 2) clk_i = ~clk_i;
  end

  // Frame length in bytes for a given format; zero for the invalid code.
  function automatic int unsigned frame_bytes(input afcu_fmt_e fmt);
    case (fmt)
      FMT_PACKED20: return (20 * NCH + 7) / 8;
      FMT_WIDE24:   return 3 * NCH;
      FMT_WIDE32:   return 4 * NCH;
      default:      return 0;
    endcase
  endfunction

  // Works out the channel result, if any, that one accepted byte causes.
  function automatic bit decode_frame_byte(input logic [7:0] b, input logic st,
                                           output afcu_result_t r);
    logic [23:0] word;
    logic [5:0]  p;
    int unsigned ch;
    int unsigned per;
    bit          hit;
    r   = '0;
    hit = 1'b0;
    ch  = 0;
    if (st) begin
      pos_q  = '0;
      held_q = '0;
      if (fmt_q == FMT_INVALID) begin
        frame_open_q = 1'b0;
        r.bad_format = 1'b1;
        return 1'b1;
      end
      frame_open_q = 1'b1;
    end
    if (!frame_open_q) return 1'b0;

    p    = pos_q;
    word = {held_q, b};
    case (fmt_q)
      FMT_PACKED20: begin
        // Two channels in five bytes: even one from the top, odd one from the bottom
        if (p % 5 == 2) begin
          ch          = 2 * (p / 5);
          r.raw_value = word[23:4];
          hit         = 1'b1;
        end else if (p % 5 == 4) begin
          ch          = 2 * (p / 5) + 1;
          r.raw_value = word[19:0];
          hit         = 1'b1;
        end
      end
      FMT_WIDE24, FMT_WIDE32: begin
        per = (fmt_q == FMT_WIDE24) ? 3 : 4;
        if (p % per == 2) begin
          ch            = p / per;
          r.raw_value   = word[23:4];
          r.range_flag  = b[3];
          r.channel_tag = b[2:0];
          hit           = 1'b1;
        end
      end
      default: ;
    endcase
    if (ch >= NCH) hit = 1'b0;

    held_q = word[15:0];
    pos_q  = p + 6'd1;
    if (fmt_q == FMT_INVALID || pos_q >= frame_bytes(fmt_q)) frame_open_q = 1'b0;

    if (!hit) begin
      r = '0;
      return 1'b0;
    end
    r.channel_index = ch[2:0];
    r.signed_value  = r.raw_value;
    r.frame_done    = (ch == NCH - 1);
    return 1'b1;
  endfunction

  function automatic string format_result(input afcu_result_t r);
    return $sformatf("ch=%0d raw=%05h sv=%05h range=%0b tag=%0d done=%0b bad=%0b",
                     r.channel_index, r.raw_value, r.signed_value, r.range_flag,
                     r.channel_tag, r.frame_done, r.bad_format);
  endfunction

  // Biased byte source so that all-zero and all-one bytes turn up often.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Sends one request; called and returning at a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic st);
    int unsigned  gap;
    afcu_result_t r;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= st;
    do @(posedge clk_i); while (!s_axis_tready);
    if (st || frame_open_q) bytes_decoded++;
    if (decode_frame_byte(b, st, r)) expected_channels.push_back(r);
    @(negedge clk_i);
  endtask

  // Holds the sender off until every expected result has arrived and the pipeline is quiet.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_channels.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_format(input logic [1:0] v);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    fmt_q = afcu_fmt_e'(v);
  endtask

  // Bytes with no frame open must be dropped silently.
  task automatic test_idle_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
  endtask

  // An invalid format gives a single error on the opening byte, then silence.
  task automatic test_invalid_format();
    write_format(FMT_INVALID);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
  endtask

  // Both channels of the first packed pair with every bit set.
  task automatic test_packed20_extremes();
    write_format(FMT_PACKED20);
    send_byte(8'hFF, 1'b1);
    repeat (4) send_byte(8'hFF, 1'b0);
  endtask

  // Zero code with the range bit and full tag, then the most negative code.
  task automatic test_wide24_extremes();
    write_format(FMT_WIDE24);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h0F, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h08, 1'b0);
  endtask

  // Most positive code in the 32-bit layout, then format changes inside an open frame.
  task automatic test_wide32_midframe_change();
    write_format(FMT_WIDE32);
    send_byte(8'h7F, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hF7, 1'b0);
    send_byte(8'h00, 1'b0);
    // Switching to 24-bit keeps the position, so byte six completes channel one
    write_format(FMT_WIDE24);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    // The invalid code closes the frame without a result
    write_format(FMT_INVALID);
    send_byte(8'h56, 1'b0);
    write_format(FMT_PACKED20);
    send_byte(8'h9A, 1'b0);
  endtask

  // Mostly whole frames with random content; some cut short, overrun, restarted or stray.
  task automatic test_random_frames(input int unsigned sender_idle,
                                    input int unsigned recv_stall,
                                    input int unsigned target);
    int unsigned first;
    int unsigned len;
    int unsigned kind;
    int unsigned restart_at;
    logic [1:0]  fmt_pick;
    logic        st;
    idle_pct  = sender_idle;
    stall_pct = recv_stall;
    first     = bytes_decoded;
    while (bytes_decoded - first < target) begin
      if ($urandom_range(3) == 0) begin
        fmt_pick = ($urandom_range(9) == 0) ? FMT_INVALID : 2'($urandom_range(2));
        write_format(fmt_pick);
      end else if ($urandom_range(19) == 0) begin
        wait_drained();
      end
      len        = frame_bytes(fmt_q);
      kind       = $urandom_range(19);
      restart_at = 64;
      if (fmt_q == FMT_INVALID) len = 1 + $urandom_range(3);
      else if (kind < 2) len = 1 + $urandom_range(len - 1);
      else if (kind < 4) len = len + 1 + $urandom_range(3);
      else if (kind == 4) len = 1 + $urandom_range(2);
      else if (kind == 5) restart_at = $urandom_range(len - 1, 1);
      for (int unsigned i = 0; i < len; i++) begin
        if (kind == 4) st = ($urandom_range(3) == 0);
        else st = (i == 0 || i == restart_at);
        send_byte(pick_byte(), st);
      end
    end
  endtask

  // Receiver readiness, changed only at falling edges.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Compare each delivered result against the oldest prediction.
  always @(posedge clk_i) begin : check_results
    afcu_result_t seen;
    afcu_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen               = '0;
      seen.channel_index = m_axis_tdata[2:0];
      seen.raw_value     = m_axis_tdata[22:3];
      seen.signed_value  = m_axis_tdata[42:23];
      seen.range_flag    = m_axis_tdata[43];
      seen.channel_tag   = m_axis_tdata[46:44];
      seen.frame_done    = m_axis_tlast;
      seen.bad_format    = m_axis_tuser;
      if (expected_channels.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result with none pending: %s", $realtime, format_result(seen));
      end else begin
        want = expected_channels.pop_front();
        if (seen !== want || m_axis_tdata[47] !== 1'b0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: mismatch, expected %s", $realtime, format_result(want));
            $display("%0t:           actual   %s pad=%0b", $realtime, format_result(seen),
                     m_axis_tdata[47]);
          end
        end
      end
    end
  end

  // Watchdog for a hung handshake.
  initial begin
    #8_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_idle_bytes();
    test_invalid_format();
    test_packed20_extremes();
    test_wide24_extremes();
    test_wide32_midframe_change();

    test_random_frames(0, 0, 480);
    test_random_frames(70, 0, 480);
    test_random_frames(0, 70, 480);
    test_random_frames(27, 27, 480);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && expected_channels.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/afcu_pkg.sv
sv/afcu_decode.sv
sv/afcu_out_buf.sv
sv/adc_frame_channel_unpacker.sv
tb/testbench.sv
